// ===== design/fpw_pkg.sv =====
package fpw_pkg;

    localparam int NUM_HARMONICS = 15;
    localparam int PHASE_BITS    = 12;
    localparam int HARM_W        = 6;
    localparam int QUARTER       = 1 << (PHASE_BITS - 2);
    localparam int TRIG_W        = 32;
    localparam int COEF_W        = 20;
    localparam int ACC_W         = 56;
    // |S| stays below 2^50, so (|S| + 200000) >> 7 fits in 44 bits
    localparam int NUM_W         = 44;
    localparam int SPLIT         = 22;
    localparam int RECIP_W       = 33;
    localparam int PP_W          = SPLIT + RECIP_W;
    localparam int SUM_W         = PP_W + SPLIT;
    localparam int QUO_W         = 33;
    localparam int DIVISOR       = 3125;
    // floor(2^44 / 3125); the estimate is low by at most one
    localparam logic [RECIP_W-1:0] RECIP = 33'd5629499534;

    typedef enum logic [2:0] {
        REG_MEAN   = 3'd0,
        REG_RATE   = 3'd1,
        REG_SWITCH = 3'd2,
        REG_SCALE  = 3'd3
    } cfg_reg_t;

    typedef struct packed {
        logic                  valid;
        logic                  pre;
        logic [PHASE_BITS-1:0] phase;
    } pipe_t;

    typedef struct packed {
        logic             valid;
        logic             pre;
        logic             neg;
        logic [NUM_W-1:0] num;
    } div_t;

    typedef struct packed {
        logic             valid;
        logic             pre;
        logic             neg;
        logic [QUO_W-1:0] quo;
    } quo_t;

    typedef logic [30:0] qsine_tab_t [QUARTER+1];

    // Quarter-wave sine in Q30, odd polynomial of degree 9, evaluated at elaboration
    function automatic qsine_tab_t build_qsine();
        qsine_tab_t  tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] p;
        logic [63:0] m;
        for (int r = 0; r <= QUARTER; r++)
        begin
            x  = 64'(r) << (30 - (PHASE_BITS - 2));
            x2 = (x * x) >> 30;
            p  = 64'd172272;
            p  = 64'd5026995 - ((x2 * p) >> 30);
            p  = 64'd85569306 - ((x2 * p) >> 30);
            p  = 64'd693598668 - ((x2 * p) >> 30);
            p  = 64'd1686629713 - ((x2 * p) >> 30);
            m  = (x * p) >> 30;
            if (m > 64'd1073741824)
                m = 64'd1073741824;
            tab[r] = m[30:0];
        end
        return tab;
    endfunction

    localparam qsine_tab_t QSINE_TAB = build_qsine();

    function automatic logic signed [TRIG_W-1:0] sine_q30(input logic [PHASE_BITS-1:0] a);
        logic [1:0]            quad;
        logic [PHASE_BITS-2:0] r;
        logic [30:0]           m;
        quad = a[PHASE_BITS-1 -: 2];
        r    = {1'b0, a[PHASE_BITS-3:0]};
        if (quad[0])
            r = (PHASE_BITS-1)'(QUARTER) - r;
        m = QSINE_TAB[r];
        return quad[1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

    // Coefficients in units of 1e-5, harmonic number from one
    function automatic logic signed [COEF_W-1:0] cos_coef(input logic [HARM_W-1:0] hn);
        logic signed [COEF_W-1:0] c;
        case (hn)
            6'd1:    c = 20'sd283586;
            6'd2:    c = -20'sd109937;
            6'd3:    c = 20'sd70761;
            6'd4:    c = 20'sd48890;
            6'd5:    c = -20'sd29543;
            6'd6:    c = 20'sd11454;
            6'd7:    c = -20'sd37011;
            6'd8:    c = 20'sd23613;
            6'd9:    c = -20'sd4670;
            6'd10:   c = 20'sd8075;
            6'd11:   c = 20'sd550;
            6'd12:   c = -20'sd7736;
            6'd13:   c = 20'sd4093;
            6'd14:   c = -20'sd3809;
            6'd15:   c = 20'sd3868;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic signed [COEF_W-1:0] sin_coef(input logic [HARM_W-1:0] hn);
        logic signed [COEF_W-1:0] c;
        case (hn)
            6'd1:    c = 20'sd13367;
            6'd2:    c = -20'sd85915;
            6'd3:    c = -20'sd104898;
            6'd4:    c = 20'sd71584;
            6'd5:    c = -20'sd6778;
            6'd6:    c = 20'sd22741;
            6'd7:    c = -20'sd13848;
            6'd8:    c = -20'sd15284;
            6'd9:    c = 20'sd8242;
            6'd10:   c = -20'sd7041;
            6'd11:   c = 20'sd12147;
            6'd12:   c = -20'sd3547;
            6'd13:   c = -20'sd1490;
            6'd14:   c = 20'sd1484;
            6'd15:   c = -20'sd5287;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// ===== design/fpw_cell.sv =====
// One harmonic: look up both trig values, then multiply and accumulate
module fpw_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [fpw_pkg::HARM_W-1:0]          harm_num,
    input  fpw_pkg::pipe_t                      in_ctl,
    input  logic signed [fpw_pkg::ACC_W-1:0]    in_acc,
    output fpw_pkg::pipe_t                      out_ctl,
    output logic signed [fpw_pkg::ACC_W-1:0]    out_acc
);

    logic [fpw_pkg::PHASE_BITS+fpw_pkg::HARM_W-1:0] ang_prod;
    logic [fpw_pkg::PHASE_BITS-1:0]                 ang;
    logic [fpw_pkg::PHASE_BITS-1:0]                 ang_cos;

    fpw_pkg::pipe_t                     ctl_a_reg, ctl_a_next;
    logic signed [fpw_pkg::ACC_W-1:0]   acc_a_reg, acc_a_next;
    logic signed [fpw_pkg::TRIG_W-1:0]  sin_reg, sin_next;
    logic signed [fpw_pkg::TRIG_W-1:0]  cos_reg, cos_next;
    fpw_pkg::pipe_t                     ctl_b_reg, ctl_b_next;
    logic signed [fpw_pkg::ACC_W-1:0]   acc_b_reg, acc_b_next;

    logic signed [fpw_pkg::COEF_W+fpw_pkg::TRIG_W-1:0] cos_term;
    logic signed [fpw_pkg::COEF_W+fpw_pkg::TRIG_W-1:0] sin_term;

    always_comb
    begin
        ang_prod   = (fpw_pkg::PHASE_BITS+fpw_pkg::HARM_W)'(harm_num) *
                     (fpw_pkg::PHASE_BITS+fpw_pkg::HARM_W)'(in_ctl.phase);
        ang        = ang_prod[fpw_pkg::PHASE_BITS-1:0];
        ang_cos    = ang + fpw_pkg::PHASE_BITS'(fpw_pkg::QUARTER);
        ctl_a_next = in_ctl;
        acc_a_next = in_acc;
        sin_next   = fpw_pkg::sine_q30(ang);
        cos_next   = fpw_pkg::sine_q30(ang_cos);
    end

    always_comb
    begin
        cos_term   = fpw_pkg::cos_coef(harm_num) * cos_reg;
        sin_term   = fpw_pkg::sin_coef(harm_num) * sin_reg;
        ctl_b_next = ctl_a_reg;
        acc_b_next = acc_a_reg + fpw_pkg::ACC_W'(cos_term) + fpw_pkg::ACC_W'(sin_term);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
        end
        else
        begin
            ctl_a_reg <= ctl_a_next;
            ctl_b_reg <= ctl_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_a_reg <= acc_a_next;
        sin_reg   <= sin_next;
        cos_reg   <= cos_next;
        acc_b_reg <= acc_b_next;
    end

    assign out_ctl = ctl_b_reg;
    assign out_acc = acc_b_reg;

endmodule

// ===== design/fpw_div_step.sv =====
// Divide by 3125: reciprocal multiply in two halves, then one correction step
module fpw_div_step (
    input  logic          clk,
    input  logic          rst_n,
    input  fpw_pkg::div_t in_div,
    output fpw_pkg::quo_t out_quo
);

    fpw_pkg::div_t                   div_a_reg, div_a_next;
    logic [fpw_pkg::PP_W-1:0]        phi_reg, phi_next;
    logic [fpw_pkg::PP_W-1:0]        plo_reg, plo_next;
    fpw_pkg::div_t                   div_b_reg, div_b_next;
    logic [fpw_pkg::QUO_W-1:0]       qest_reg, qest_next;
    fpw_pkg::quo_t                   quo_reg, quo_next;

    logic [fpw_pkg::SUM_W-1:0]       sum;
    logic [fpw_pkg::NUM_W-1:0]       back;
    logic [fpw_pkg::NUM_W-1:0]       rem;

    // Partial products of the upper and lower halves
    always_comb
    begin
        div_a_next = in_div;
        phi_next   = fpw_pkg::PP_W'(in_div.num[fpw_pkg::NUM_W-1:fpw_pkg::SPLIT]) *
                     fpw_pkg::PP_W'(fpw_pkg::RECIP);
        plo_next   = fpw_pkg::PP_W'(in_div.num[fpw_pkg::SPLIT-1:0]) *
                     fpw_pkg::PP_W'(fpw_pkg::RECIP);
    end

    // Combine and keep the quotient estimate
    always_comb
    begin
        sum        = {phi_reg, {fpw_pkg::SPLIT{1'b0}}} + fpw_pkg::SUM_W'(plo_reg);
        div_b_next = div_a_reg;
        qest_next  = sum[fpw_pkg::SUM_W-1 -: fpw_pkg::QUO_W];
    end

    // Bump the estimate when the remainder still holds a divisor
    always_comb
    begin
        back           = fpw_pkg::NUM_W'(fpw_pkg::NUM_W'(qest_reg) *
                                         fpw_pkg::NUM_W'(fpw_pkg::DIVISOR));
        rem            = div_b_reg.num - back;
        quo_next.valid = div_b_reg.valid;
        quo_next.pre   = div_b_reg.pre;
        quo_next.neg   = div_b_reg.neg;
        if (rem >= fpw_pkg::NUM_W'(fpw_pkg::DIVISOR))
            quo_next.quo = qest_reg + fpw_pkg::QUO_W'(1);
        else
            quo_next.quo = qest_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_a_reg <= '0;
            div_b_reg <= '0;
            quo_reg   <= '0;
        end
        else
        begin
            div_a_reg <= div_a_next;
            div_b_reg <= div_b_next;
            quo_reg   <= quo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        phi_reg  <= phi_next;
        plo_reg  <= plo_next;
        qest_reg <= qest_next;
    end

    assign out_quo = quo_reg;

endmodule

// ===== design/fourier_pulse_waveform_top.sv =====
// Stages: dt, phase, each cell's a and b registers, prep, 3 divide stages, scale product, output.
// Throughput: one request per cycle; busy stays low, every cell stage advances each cycle.
// The result appears for one cycle with result_valid; the receiver cannot stall.
// Reset (rst_n low, asynchronous) empties the pipeline and restores register defaults.
module fourier_pulse_waveform_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [31:0]        time_now,
    output logic               result_valid,
    output logic signed [31:0] magnitude_velocity,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    // Configuration registers
    logic [31:0] mean_reg, mean_next;
    logic [31:0] rate_reg, rate_next;
    logic [31:0] switch_reg, switch_next;
    logic [31:0] scale_reg, scale_next;

    // Front end: elapsed time, then phase
    logic        v0_reg, v0_next;
    logic        pre0_reg, pre0_next;
    logic [31:0] dt_reg, dt_next;
    logic [63:0] cyc_prod;
    fpw_pkg::pipe_t ph_reg, ph_next;

    // Harmonic chain
    fpw_pkg::pipe_t                   chain_ctl [fpw_pkg::NUM_HARMONICS+1];
    logic signed [fpw_pkg::ACC_W-1:0] chain_acc [fpw_pkg::NUM_HARMONICS+1];

    // Back end
    logic [fpw_pkg::ACC_W-1:0] mag;
    logic [fpw_pkg::ACC_W:0]   mag_rnd;
    fpw_pkg::div_t             prep_reg, prep_next;
    fpw_pkg::quo_t             div_out;
    logic                      mv_reg, mv_next;
    logic                      mpre_reg, mpre_next;
    logic                      mneg_reg, mneg_next;
    logic [63:0]               mprod_reg, mprod_next;
    logic [64:0]               d_sum;
    logic [28:0]               d_val;
    logic signed [33:0]        res_wide;
    logic                      out_v_reg, out_v_next;
    logic [31:0]               out_reg, out_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Register writes; unknown indexes drop silently
    always_comb
    begin
        mean_next   = mean_reg;
        rate_next   = rate_reg;
        switch_next = switch_reg;
        scale_next  = scale_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                fpw_pkg::REG_MEAN:   mean_next   = cfg_data;
                fpw_pkg::REG_RATE:   rate_next   = cfg_data;
                fpw_pkg::REG_SWITCH: switch_next = cfg_data;
                fpw_pkg::REG_SCALE:  scale_next  = cfg_data;
                default:             ;
            endcase
        end
    end

    // Stage 0: compare against switch-on and take the elapsed time
    always_comb
    begin
        v0_next   = start;
        pre0_next = time_now < switch_reg;
        dt_next   = time_now - switch_reg;
    end

    // Stage 1: scale by the cycle rate and keep the fractional cycle
    always_comb
    begin
        cyc_prod      = 64'(dt_reg) * 64'(rate_reg);
        ph_next.valid = v0_reg;
        ph_next.pre   = pre0_reg;
        ph_next.phase = cyc_prod[39 -: fpw_pkg::PHASE_BITS];
    end

    assign chain_ctl[0] = ph_reg;
    assign chain_acc[0] = '0;

    // One cell per harmonic, each handing its partial sum to the next
    for (genvar g = 0; g < fpw_pkg::NUM_HARMONICS; g++)
    begin : g_cell
        fpw_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .harm_num (fpw_pkg::HARM_W'(g + 1)),
            .in_ctl   (chain_ctl[g]),
            .in_acc   (chain_acc[g]),
            .out_ctl  (chain_ctl[g+1]),
            .out_acc  (chain_acc[g+1])
        );
    end

    // Magnitude, half-unit bias, and the power-of-two part of the divide by 400000
    always_comb
    begin
        mag = chain_acc[fpw_pkg::NUM_HARMONICS][fpw_pkg::ACC_W-1]
              ? fpw_pkg::ACC_W'(-chain_acc[fpw_pkg::NUM_HARMONICS])
              : fpw_pkg::ACC_W'(chain_acc[fpw_pkg::NUM_HARMONICS]);
        mag_rnd         = {1'b0, mag} + (fpw_pkg::ACC_W+1)'(200000);
        prep_next.valid = chain_ctl[fpw_pkg::NUM_HARMONICS].valid;
        prep_next.pre   = chain_ctl[fpw_pkg::NUM_HARMONICS].pre;
        prep_next.neg   = chain_acc[fpw_pkg::NUM_HARMONICS][fpw_pkg::ACC_W-1];
        // The harmonic sum is bounded well below 2^50, so drop the empty top bits
        prep_next.num   = mag_rnd[fpw_pkg::NUM_W+6:7];
    end

    // Remaining divide by 3125
    fpw_div_step u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_div  (prep_reg),
        .out_quo (div_out)
    );

    // Apply the flow scale; the rounded sum stays below 2^32
    always_comb
    begin
        mv_next    = div_out.valid;
        mpre_next  = div_out.pre;
        mneg_next  = div_out.neg;
        mprod_next = 64'(div_out.quo[31:0]) * 64'(scale_reg);
    end

    // Round to Q24, apply sign, subtract from the mean and saturate; before switch-on pass the mean
    always_comb
    begin
        d_sum = {1'b0, mprod_reg} + (65'd1 << 35);
        d_val = d_sum[64:36];
        if (mneg_reg)
            res_wide = 34'(signed'(mean_reg)) + $signed({5'b0, d_val});
        else
            res_wide = 34'(signed'(mean_reg)) - $signed({5'b0, d_val});
        out_v_next = mv_reg;
        if (mpre_reg)
            out_next = mean_reg;
        else if (res_wide > 34'sh0_7FFF_FFFF)
            out_next = 32'h7FFF_FFFF;
        else if (res_wide < -34'sh0_8000_0000)
            out_next = 32'h8000_0000;
        else
            out_next = res_wide[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg   <= '0;
            rate_reg   <= 32'd20971520;
            switch_reg <= '0;
            scale_reg  <= '0;
            v0_reg     <= 1'b0;
            ph_reg     <= '0;
            prep_reg   <= '0;
            mv_reg     <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            mean_reg   <= mean_next;
            rate_reg   <= rate_next;
            switch_reg <= switch_next;
            scale_reg  <= scale_next;
            v0_reg     <= v0_next;
            ph_reg     <= ph_next;
            prep_reg   <= prep_next;
            mv_reg     <= mv_next;
            out_v_reg  <= out_v_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pre0_reg  <= pre0_next;
        dt_reg    <= dt_next;
        mpre_reg  <= mpre_next;
        mneg_reg  <= mneg_next;
        mprod_reg <= mprod_next;
        out_reg   <= out_next;
    end

    assign result_valid       = out_v_reg;
    assign magnitude_velocity = out_reg;

endmodule

// ===== test/tb_fourier_pulse_waveform_top.sv =====
module tb_fourier_pulse_waveform_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Covers the full pipeline depth, plus margin
    localparam int DRAIN_CYCLES = 60;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [31:0]        time_now;
    logic               result_valid;
    logic signed [31:0] magnitude_velocity;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    // Shadow copy of the configuration registers
    logic signed [31:0] mean_q;
    logic [31:0]        rate_q;
    logic [31:0]        switch_q;
    logic [31:0]        scale_q;

    // Expected velocities, oldest first
    logic signed [31:0] velocity_fifo[$];
    int                 failures;
    int                 gap_pct;

    // Harmonic coefficients in units of 1e-5, harmonic one first
    int cos_tab[15] = '{283586, -109937, 70761, 48890, -29543, 11454, -37011, 23613,
                        -4670, 8075, 550, -7736, 4093, -3809, 3868};
    int sin_tab[15] = '{13367, -85915, -104898, 71584, -6778, 22741, -13848, -15284,
                        8242, -7041, 12147, -3547, -1490, 1484, -5287};

    typedef struct {
        logic [31:0]        t;
        bit                 known;
        logic signed [31:0] v;
    } vec_t;

    fourier_pulse_waveform_top dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Quarter-wave sine in Q30 for r in [0, QUARTER]
    function automatic longint quarter_wave(input int r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] p;
        logic [63:0] m;
        x  = 64'(r) << (30 - (fpw_pkg::PHASE_BITS - 2));
        x2 = (x * x) >> 30;
        p  = 64'd5026995 - ((x2 * 64'd172272) >> 30);
        p  = 64'd85569306 - ((x2 * p) >> 30);
        p  = 64'd693598668 - ((x2 * p) >> 30);
        p  = 64'd1686629713 - ((x2 * p) >> 30);
        m  = (x * p) >> 30;
        if (m > 64'd1073741824)
            m = 64'd1073741824;
        return longint'(m);
    endfunction

    function automatic longint phase_sine(input int a);
        int quad;
        int r;
        longint m;
        a    = a & ((1 << fpw_pkg::PHASE_BITS) - 1);
        quad = (a >> (fpw_pkg::PHASE_BITS - 2)) & 3;
        r    = a & (fpw_pkg::QUARTER - 1);
        if (quad & 1)
            r = fpw_pkg::QUARTER - r;
        m = quarter_wave(r);
        return (quad & 2) ? -m : m;
    endfunction

    function automatic logic signed [31:0] flow_velocity(input logic [31:0] t);
        longint      res;
        logic [63:0] prod;
        int          ph;
        int          a;
        longint      acc;
        logic [63:0] mag;
        logic [63:0] m28;
        logic [63:0] d;
        if (t < switch_q)
            res = mean_q;
        else
        begin
            prod = 64'(t - switch_q) * 64'(rate_q);
            ph   = int'((prod >> (40 - fpw_pkg::PHASE_BITS)) &
                        ((1 << fpw_pkg::PHASE_BITS) - 1));
            acc  = 0;
            for (int k = 0; k < fpw_pkg::NUM_HARMONICS; k++)
            begin
                a   = ((k + 1) * ph) & ((1 << fpw_pkg::PHASE_BITS) - 1);
                acc += longint'(cos_tab[k]) * phase_sine(a + fpw_pkg::QUARTER)
                     + longint'(sin_tab[k]) * phase_sine(a);
            end
            mag = acc < 0 ? 64'(-acc) : 64'(acc);
            m28 = (mag + 64'd200000) / 64'd400000;
            d   = (m28 * 64'(scale_q) + (64'd1 << 35)) >> 36;
            res = acc < 0 ? longint'(mean_q) + longint'(d) : longint'(mean_q) - longint'(d);
        end
        if (res > 64'sd2147483647)
            res = 64'sd2147483647;
        if (res < -64'sd2147483648)
            res = -64'sd2147483648;
        return res[31:0];
    endfunction

    // Write one register while the pipeline is empty; hold until ready
    task automatic write_reg(input fpw_pkg::cfg_reg_t idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            fpw_pkg::REG_MEAN:   mean_q   = value;
            fpw_pkg::REG_RATE:   rate_q   = value;
            fpw_pkg::REG_SWITCH: switch_q = value;
            fpw_pkg::REG_SCALE:  scale_q  = value;
            default: ;
        endcase
    endtask

    // Index beyond the register file must be ignored
    task automatic write_stray(input logic [2:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Offer one request; keep start high across back-to-back requests
    task automatic send_sample(input logic [31:0] t, input logic signed [31:0] v);
        while ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start    <= 1'b1;
        time_now <= t;
        do
            @(posedge clk);
        while (busy);
        velocity_fifo.push_back(v);
    endtask

    task automatic drain();
        while (velocity_fifo.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_time();
        case ($urandom_range(3))
            0:       return $urandom_range(32'h0003_0000);
            1:       return switch_q + $urandom_range(32'h0004_0000);
            default: return $urandom();
        endcase
    endfunction

    // Check each strobed result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (velocity_fifo.size() == 0)
            begin
                failures++;
                $display("%t: unexpected result %0d", $time, magnitude_velocity);
            end
            else
            begin
                logic signed [31:0] exp_v;
                exp_v = velocity_fifo.pop_front();
                if (exp_v !== magnitude_velocity)
                begin
                    failures++;
                    $display("%t: velocity expected %0d actual %0d",
                             $time, exp_v, magnitude_velocity);
                end
            end
        end
    end

    initial
    begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        vec_t        dir[$];
        logic [31:0] t;
        clk       = 1'b0;
        rst_n     = 1'b0;
        start     = 1'b0;
        time_now  = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        failures  = 0;
        gap_pct   = 0;
        mean_q    = 0;
        rate_q    = 32'd20971520;
        switch_q  = 0;
        scale_q   = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // After reset the scale is zero, so every sample reads the mean of zero
        dir.push_back('{32'h0000_0000, 1'b1, 32'sd0});
        dir.push_back('{32'hFFFF_FFFF, 1'b1, 32'sd0});
        dir.push_back('{32'h0000_CCCD, 1'b1, 32'sd0});
        foreach (dir[i])
            send_sample(dir[i].t, dir[i].v);
        start <= 1'b0;
        drain();

        // Before switch-on the mean passes straight through
        write_reg(fpw_pkg::REG_MEAN, 32'h8000_0000);
        write_reg(fpw_pkg::REG_SWITCH, 32'hFFFF_FFFF);
        write_reg(fpw_pkg::REG_SCALE, 32'hFFFF_FFFF);
        write_stray(3'd5, 32'h1234_5678);
        write_stray(3'd7, 32'hDEAD_BEEF);
        dir.delete();
        dir.push_back('{32'h0000_0000, 1'b1, 32'sh8000_0000});
        dir.push_back('{32'hFFFF_FFFE, 1'b1, 32'sh8000_0000});
        dir.push_back('{32'hFFFF_FFFF, 1'b0, 32'sd0});
        foreach (dir[i])
            send_sample(dir[i].t, dir[i].known ? dir[i].v : flow_velocity(dir[i].t));
        start <= 1'b0;
        drain();

        // Full scale with the mean at the top rail drives saturation; rate extremes wrap the phase
        write_reg(fpw_pkg::REG_SWITCH, 32'd0);
        write_reg(fpw_pkg::REG_MEAN, 32'h7FFF_FFFF);
        write_reg(fpw_pkg::REG_RATE, 32'hFFFF_FFFF);
        dir.delete();
        for (int i = 0; i < 8; i++)
            dir.push_back('{32'h0000_1000 * i + 32'h0000_0123, 1'b0, 32'sd0});
        dir.push_back('{32'hFFFF_FFFF, 1'b0, 32'sd0});
        dir.push_back('{32'h8000_0000, 1'b0, 32'sd0});
        foreach (dir[i])
            send_sample(dir[i].t, flow_velocity(dir[i].t));
        start <= 1'b0;
        drain();
        write_reg(fpw_pkg::REG_RATE, 32'd0);
        send_sample(32'h0001_2345, flow_velocity(32'h0001_2345));
        send_sample(32'h5555_AAAA, flow_velocity(32'h5555_AAAA));
        start <= 1'b0;
        drain();

        // Random phases: idle mix and configuration change every phase
        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph % 4)
                0: gap_pct = 0;
                1: gap_pct = 76;
                2: gap_pct = 0;
                default: gap_pct = 15;
            endcase
            write_reg(fpw_pkg::REG_MEAN, (ph % 5 == 0) ? 32'h8000_0000 : $urandom());
            write_reg(fpw_pkg::REG_RATE, (ph % 6 == 1) ? 32'hFFFF_FFFF :
                      ($urandom_range(1) ? $urandom() : $urandom_range(32'h0400_0000)));
            write_reg(fpw_pkg::REG_SWITCH, (ph % 4 == 3) ? 32'hFFFF_FFFF :
                      ($urandom_range(1) ? 32'd0 : $urandom()));
            write_reg(fpw_pkg::REG_SCALE, (ph % 6 == 2) ? 32'hFFFF_FFFF :
                      ($urandom_range(1) ? $urandom() : $urandom_range(32'h00FF_FFFF)));
            for (int n = 0; n < 110; n++)
            begin
                t = rand_time();
                send_sample(t, flow_velocity(t));
            end
            start <= 1'b0;
            drain();
        end

        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
